[rtl/hru_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hru_pkg
// Shared types and constants for the hashed random unit vector block.
// ----------------------------------------------------------------------------
package hru_pkg;

  localparam int FRAC_BITS_DEF = 30;
  localparam int WORD_W        = 32;
  localparam int NUM_LANES     = 3;
  localparam int Q_DEPTH       = 4;

  // noise hash and seed fold constants
  localparam logic [31:0] NOISE_M1   = 32'hB529_7A4D;
  localparam logic [31:0] NOISE_A2   = 32'h68E3_1DA4;
  localparam logic [31:0] NOISE_M3   = 32'h1B56_C4E9;
  localparam logic [31:0] HASH_BIAS  = 32'd1;
  localparam logic [31:0] SEED_MUL_Y = 32'd198491317;
  localparam logic [31:0] SEED_MUL_Z = 32'd6542989;

  localparam int HASH_SH = 8;
  localparam int XS_A    = 13;
  localparam int XS_B    = 17;
  localparam int XS_C    = 5;

  typedef struct packed {
    logic signed [WORD_W-1:0] seed_x;
    logic signed [WORD_W-1:0] seed_y;
    logic signed [WORD_W-1:0] seed_z;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] dir_x;
    logic signed [WORD_W-1:0] dir_y;
    logic signed [WORD_W-1:0] dir_z;
    logic                     degenerate;
  } out_word_t;

  // three successive xorshift draws for one item
  typedef struct packed {
    logic [WORD_W-1:0] r1;
    logic [WORD_W-1:0] r2;
    logic [WORD_W-1:0] r3;
  } rnd_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[rtl/hru_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hru_front
// Seed fold, noise hash and three xorshift draws, pipelined, one word per
// cycle. Pushes the draws into the queue; stalls as a whole when it is full.
// ----------------------------------------------------------------------------
module hru_front import hru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  input  q_stat_t   q_stat,
  output logic      push,
  output rnd_word_t push_word
);

  function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    a = v ^ (v << XS_A);
    b = a ^ (a >> XS_B);
    xs_step = b ^ (b << XS_C);
  endfunction

  logic              adv;
  logic [6:0]        vld_r;
  logic [WORD_W-1:0] sx_r, py_r, pz_r;
  logic [WORD_W-1:0] c_r, h_r, w_r, m_r, r1_r;
  rnd_word_t         word_r;

  logic [WORD_W-1:0] py_nxt, pz_nxt, c_nxt, h_nxt, m_nxt;
  logic [WORD_W-1:0] w1, w2, w3, w_nxt, m1, r1_nxt;
  rnd_word_t         word_nxt;

  assign adv      = !q_stat.full;
  assign in_stall = q_stat.full;
  assign push     = adv && vld_r[6];
  assign push_word = word_r;

  always_comb begin
    py_nxt = WORD_W'(in_word.seed_y) * SEED_MUL_Y;
    pz_nxt = WORD_W'(in_word.seed_z) * SEED_MUL_Z;
    c_nxt  = sx_r + py_r + pz_r;
    h_nxt  = c_r * NOISE_M1;
    w1     = h_r + HASH_BIAS;
    w2     = w1 ^ (w1 >> HASH_SH);
    w3     = w2 + NOISE_A2;
    w_nxt  = w3 ^ (w3 << HASH_SH);
    m_nxt  = w_r * NOISE_M3;
    m1     = m_r ^ (m_r >> HASH_SH);
    r1_nxt = xs_step(m1);
    word_nxt.r1 = r1_r;
    word_nxt.r2 = xs_step(r1_r);
    word_nxt.r3 = xs_step(word_nxt.r2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r   <= WORD_W'(in_word.seed_x);
      py_r   <= py_nxt;
      pz_r   <= pz_nxt;
      c_r    <= c_nxt;
      h_r    <= h_nxt;
      w_r    <= w_nxt;
      m_r    <= m_nxt;
      r1_r   <= r1_nxt;
      word_r <= word_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/hru_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hru_fifo
// Short queue of random draws between the hash front and the vector back.
// ----------------------------------------------------------------------------
module hru_fifo import hru_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rnd_word_t push_word,
  input  logic      pop,
  output rnd_word_t pop_word,
  output q_stat_t   q_stat
);

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  rnd_word_t      mem_r [Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]  count_r, count_nxt;

  assign pop_word     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue pop while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue count lost a word");

endmodule
`default_nettype wire

[rtl/hru_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hru_isqrt
// Pipelined integer square root, one root bit per stage, with side data
// carried alongside. Floor result.
// ----------------------------------------------------------------------------
module hru_isqrt #(
  parameter int W_IN   = 62,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [W_IN-1:0]     in_arg,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [W_IN/2-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int N  = W_IN / 2;
  localparam int RW = N + 3;

  logic              vld_r  [N];
  logic [RW-1:0]     rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [W_IN-1:0]   arg_r  [N];
  logic [SIDE_W-1:0] side_r [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [RW-1:0]     rem_in, cur, trial, rem_nxt;
    logic [N-1:0]      root_in, root_nxt;
    logic [W_IN-1:0]   arg_in;
    logic [SIDE_W-1:0] side_in;
    logic              v_in, ge;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign arg_in  = in_arg;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
      assign arg_in  = arg_r[s-1];
      assign side_in = side_r[s-1];
      assign v_in    = vld_r[s-1];
    end

    always_comb begin
      cur      = {rem_in[RW-3:0], arg_in[2*(N-1-s)+1 -: 2]};
      trial    = {1'b0, root_in, 2'b01};
      ge       = (cur >= trial);
      rem_nxt  = ge ? cur - trial : cur;
      root_nxt = {root_in[N-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        arg_r[s]  <= arg_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule
`default_nettype wire

[rtl/hru_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hru_div
// Pipelined restoring divider, three lanes over a shared denominator:
// quo = (mag << (MW-1)) / den, one quotient bit per stage. Needs mag <= den.
// ----------------------------------------------------------------------------
module hru_div import hru_pkg::*; #(
  parameter int MW     = 31,
  parameter int SIDE_W = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [MW-1:0]                 in_den,
  input  logic [NUM_LANES-1:0][MW-1:0]  in_mag,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [NUM_LANES-1:0][MW-1:0]  out_quo,
  output logic [SIDE_W-1:0]             out_side
);

  localparam int RW = MW + 1;

  logic                         vld_r  [MW];
  logic [NUM_LANES-1:0][RW-1:0] rem_r  [MW];
  logic [NUM_LANES-1:0][MW-1:0] quo_r  [MW];
  logic [MW-1:0]                den_r  [MW];
  logic [SIDE_W-1:0]            side_r [MW];

  for (genvar k = 0; k < MW; k++) begin : g_stage
    logic [NUM_LANES-1:0][RW-1:0] rem_in, rem_nxt;
    logic [NUM_LANES-1:0][MW-1:0] quo_in, quo_nxt;
    logic [NUM_LANES-1:0]         bit_in;
    logic [MW-1:0]                den_in;
    logic [SIDE_W-1:0]            side_in;
    logic                         v_in;

    if (k == 0) begin : g_first
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        assign rem_in[l] = {2'b00, in_mag[l][MW-1:1]};
        assign bit_in[l] = in_mag[l][0];
      end
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign bit_in  = '0;
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign v_in    = vld_r[k-1];
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane_step
      logic [RW-1:0] cur;
      logic          ge;
      always_comb begin
        cur          = {rem_in[l][RW-2:0], bit_in[l]};
        ge           = (cur >= {1'b0, den_in});
        rem_nxt[l]   = ge ? cur - {1'b0, den_in} : cur;
        quo_nxt[l]   = {quo_in[l][MW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[MW-1];
  assign out_quo   = quo_r[MW-1];
  assign out_side  = side_r[MW-1];

endmodule
`default_nettype wire

[rtl/hru_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hru_back
// Vector pipeline: fractions, x/y/z picks with root stages, length root,
// three-lane normalize divider and the output register.
// ----------------------------------------------------------------------------
module hru_back import hru_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  output logic      pop,
  input  rnd_word_t pop_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int F  = FRAC_BITS;
  localparam int W1 = F + 1;      // magnitude, 0..ONE
  localparam int WS = F + 2;
  localparam int W2 = 2 * F + 2;  // squares and their sum
  localparam int TW = F + 3;

  localparam logic [W1-1:0] HALF_1 = {2'b01, {(F-1){1'b0}}};
  localparam logic [WS-1:0] ONE_S  = {2'b01, {F{1'b0}}};
  localparam logic signed [WORD_W-1:0] ONE32 = {{(WORD_W-WS){1'b0}}, ONE_S};

  typedef struct packed {
    logic          sx;
    logic [W1-1:0] ax;
    logic [W2-1:0] sqx;
    logic [W1-1:0] fy;
    logic [W1-1:0] fz;
  } s1_t;

  typedef struct packed {
    logic          sx;
    logic [W1-1:0] ax;
    logic [W2-1:0] sqx;
    logic          sy;
    logic [W1-1:0] ay;
    logic [W2-1:0] sqy;
    logic [W1-1:0] fz;
  } s2_t;

  typedef struct packed {
    logic          sx;
    logic [W1-1:0] ax;
    logic          sy;
    logic [W1-1:0] ay;
    logic          sz;
    logic [W1-1:0] az;
  } comp_t;

  typedef struct packed {
    comp_t c;
    logic  deg;
  } s3_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic                 deg;
  } sd_t;

  // floor(r * 2^F / (2^32 - 1)): hi + lo form, one correction
  function automatic logic [W1-1:0] to_frac(input logic [WORD_W-1:0] r);
    logic [F-1:0]      hi;
    logic [WORD_W-1:0] lo;
    logic [WORD_W:0]   sum;
    hi = r[WORD_W-1 -: F];
    lo = {r[WORD_W-1-F:0], {F{1'b0}}};
    sum = {1'b0, lo} + {{(WORD_W+1-F){1'b0}}, hi};
    to_frac = {1'b0, hi} + {{F{1'b0}}, (sum >= {1'b0, {WORD_W{1'b1}}})};
  endfunction

  logic en;
  logic out_valid_r;
  out_word_t out_word_r;

  assign en        = !out_valid_r || !out_stall;
  assign pop       = en && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // stage A: fractions
  logic          va_r;
  logic [W1-1:0] fx_a_r, fy_a_r, fz_a_r;

  // stage B: x sign and magnitude
  logic          vb_r, sx_b_r;
  logic [W1-1:0] ax_b_r, fy_b_r, fz_b_r;
  logic [WS-1:0] dbl_x, dx_pos, dx_neg;

  // stage C: x squared
  logic          vc_r, sx_c_r;
  logic [W1-1:0] ax_c_r, fy_c_r, fz_c_r;
  logic [W2-1:0] sqx_c_r;

  always_comb begin
    dbl_x  = {fx_a_r, 1'b0};
    dx_pos = dbl_x - ONE_S;
    dx_neg = ONE_S - dbl_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= pop;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fx_a_r  <= to_frac(pop_word.r1);
      fy_a_r  <= to_frac(pop_word.r2);
      fz_a_r  <= to_frac(pop_word.r3);
      sx_b_r  <= (fx_a_r < HALF_1);
      ax_b_r  <= (fx_a_r < HALF_1) ? dx_neg[W1-1:0] : dx_pos[W1-1:0];
      fy_b_r  <= fy_a_r;
      fz_b_r  <= fz_a_r;
      sx_c_r  <= sx_b_r;
      ax_c_r  <= ax_b_r;
      fy_c_r  <= fy_b_r;
      fz_c_r  <= fz_b_r;
      sqx_c_r <= ax_b_r * ax_b_r;
    end
  end

  // y range root: sqrt((ONE - x2) << F)
  logic [WS-1:0] x2_c, ry_c;
  logic [W2-1:0] arg1;
  s1_t           s1_in, s1_out;
  logic          v1_out;
  logic [W1-1:0] ymax;

  always_comb begin
    x2_c      = sqx_c_r[W2-1:F];
    ry_c      = ONE_S - x2_c;
    arg1      = {1'b0, ry_c[W1-1:0], {F{1'b0}}};
    s1_in.sx  = sx_c_r;
    s1_in.ax  = ax_c_r;
    s1_in.sqx = sqx_c_r;
    s1_in.fy  = fy_c_r;
    s1_in.fz  = fz_c_r;
  end

  hru_isqrt #(.W_IN(W2), .SIDE_W($bits(s1_t))) u_root_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vc_r),
    .in_arg   (arg1),
    .in_side  (s1_in),
    .out_valid(v1_out),
    .out_root (ymax),
    .out_side (s1_out)
  );

  // stages D, E, G: spread y, square it
  logic          vd_r, ve_r, vg_r;
  logic [W2-1:0] py_d_r;
  logic [W1-1:0] ymax_d_r;
  s1_t           s1_d_r, s1_e_r, s1_g_r;
  logic          sy_e_r, sy_g_r;
  logic [W1-1:0] ay_e_r, ay_g_r;
  logic [W2-1:0] sqy_g_r;
  logic [TW-1:0] ty, ymx, dy_pos, dy_neg;

  always_comb begin
    ty     = py_d_r[W2-1:F-1];
    ymx    = {2'b00, ymax_d_r};
    dy_pos = ty - ymx;
    dy_neg = ymx - ty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vg_r <= 1'b0;
    end else if (en) begin
      vd_r <= v1_out;
      ve_r <= vd_r;
      vg_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      py_d_r   <= ymax * s1_out.fy;
      ymax_d_r <= ymax;
      s1_d_r   <= s1_out;
      sy_e_r   <= (ty < ymx);
      ay_e_r   <= (ty < ymx) ? dy_neg[W1-1:0] : dy_pos[W1-1:0];
      s1_e_r   <= s1_d_r;
      sy_g_r   <= sy_e_r;
      ay_g_r   <= ay_e_r;
      sqy_g_r  <= ay_e_r * ay_e_r;
      s1_g_r   <= s1_e_r;
    end
  end

  // z range root: remainder clamped at zero
  logic [WS-1:0] x2_g, y2_g, sxy_g, rz_g;
  logic [W2-1:0] arg2;
  s2_t           s2_in, s2_out;
  logic          v2_out;
  logic [W1-1:0] zmax;

  always_comb begin
    x2_g      = s1_g_r.sqx[W2-1:F];
    y2_g      = sqy_g_r[W2-1:F];
    sxy_g     = x2_g + y2_g;
    rz_g      = (sxy_g >= ONE_S) ? '0 : ONE_S - sxy_g;
    arg2      = {1'b0, rz_g[W1-1:0], {F{1'b0}}};
    s2_in.sx  = s1_g_r.sx;
    s2_in.ax  = s1_g_r.ax;
    s2_in.sqx = s1_g_r.sqx;
    s2_in.sy  = sy_g_r;
    s2_in.ay  = ay_g_r;
    s2_in.sqy = sqy_g_r;
    s2_in.fz  = s1_g_r.fz;
  end

  hru_isqrt #(.W_IN(W2), .SIDE_W($bits(s2_t))) u_root_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vg_r),
    .in_arg   (arg2),
    .in_side  (s2_in),
    .out_valid(v2_out),
    .out_root (zmax),
    .out_side (s2_out)
  );

  // stages H, I, J, K: spread z, square, sum of squares
  logic          vh_r, vi_r, vj_r, vk_r;
  logic [W2-1:0] pz_h_r;
  logic [W1-1:0] zmax_h_r;
  s2_t           s2_h_r, s2_i_r, s2_j_r;
  logic          sz_i_r, sz_j_r;
  logic [W1-1:0] az_i_r, az_j_r;
  logic [W2-1:0] sqz_j_r;
  logic [W2-1:0] len2_k_r;
  comp_t         comp_k_r, comp_j;
  logic [TW-1:0] tz, zmx, dz_pos, dz_neg;

  always_comb begin
    tz        = pz_h_r[W2-1:F-1];
    zmx       = {2'b00, zmax_h_r};
    dz_pos    = tz - zmx;
    dz_neg    = zmx - tz;
    comp_j.sx = s2_j_r.sx;
    comp_j.ax = s2_j_r.ax;
    comp_j.sy = s2_j_r.sy;
    comp_j.ay = s2_j_r.ay;
    comp_j.sz = sz_j_r;
    comp_j.az = az_j_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vh_r <= 1'b0;
      vi_r <= 1'b0;
      vj_r <= 1'b0;
      vk_r <= 1'b0;
    end else if (en) begin
      vh_r <= v2_out;
      vi_r <= vh_r;
      vj_r <= vi_r;
      vk_r <= vj_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pz_h_r   <= zmax * s2_out.fz;
      zmax_h_r <= zmax;
      s2_h_r   <= s2_out;
      sz_i_r   <= (tz < zmx);
      az_i_r   <= (tz < zmx) ? dz_neg[W1-1:0] : dz_pos[W1-1:0];
      s2_i_r   <= s2_h_r;
      sz_j_r   <= sz_i_r;
      az_j_r   <= az_i_r;
      sqz_j_r  <= az_i_r * az_i_r;
      s2_j_r   <= s2_i_r;
      // each square <= 2^(2F), so the sum stays below 2^(2F+2)
      len2_k_r <= s2_j_r.sqx + s2_j_r.sqy + sqz_j_r;
      comp_k_r <= comp_j;
    end
  end

  // length root
  s3_t           s3_in, s3_out;
  logic          v3_out;
  logic [W1-1:0] len;

  always_comb begin
    s3_in.c   = comp_k_r;
    s3_in.deg = (len2_k_r == '0);
  end

  hru_isqrt #(.W_IN(W2), .SIDE_W($bits(s3_t))) u_root_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (vk_r),
    .in_arg   (len2_k_r),
    .in_side  (s3_in),
    .out_valid(v3_out),
    .out_root (len),
    .out_side (s3_out)
  );

  // normalize: |c| * ONE / len per lane
  logic [NUM_LANES-1:0][W1-1:0] mags, quo;
  sd_t                          sd_in, sd_out;
  logic                         vq_out;

  always_comb begin
    mags[0]   = s3_out.c.ax;
    mags[1]   = s3_out.c.ay;
    mags[2]   = s3_out.c.az;
    sd_in.neg = {s3_out.c.sz, s3_out.c.sy, s3_out.c.sx};
    sd_in.deg = s3_out.deg;
  end

  hru_div #(.MW(W1), .SIDE_W($bits(sd_t))) u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_out),
    .in_den   (len),
    .in_mag   (mags),
    .in_side  (sd_in),
    .out_valid(vq_out),
    .out_quo  (quo),
    .out_side (sd_out)
  );

  logic [NUM_LANES-1:0][WORD_W-1:0] dir_nxt;
  out_word_t                        out_word_nxt;

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      dir_nxt[l] = {{(WORD_W-W1){1'b0}}, quo[l]};
      if (sd_out.neg[l]) dir_nxt[l] = -dir_nxt[l];
      if (sd_out.deg) dir_nxt[l] = '0;
    end
    out_word_nxt.dir_x      = dir_nxt[0];
    out_word_nxt.dir_y      = dir_nxt[1];
    out_word_nxt.dir_z      = dir_nxt[2];
    out_word_nxt.degenerate = sd_out.deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vq_out;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= out_word_nxt;
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.degenerate) |->
      (out_word_r.dir_x == '0 && out_word_r.dir_y == '0 && out_word_r.dir_z == '0))
    else $error("degenerate word with nonzero direction");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.degenerate) |->
      (out_word_r.dir_x <= ONE32 && out_word_r.dir_x >= -ONE32 &&
       out_word_r.dir_y <= ONE32 && out_word_r.dir_y >= -ONE32 &&
       out_word_r.dir_z <= ONE32 && out_word_r.dir_z >= -ONE32))
    else $error("direction component beyond one");

endmodule
`default_nettype wire

[rtl/hashed_random_unit_vector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_random_unit_vector
// Hashed seed to random unit direction, fixed point with FRAC_BITS fraction.
// Throughput: one word per cycle while out_stall is low, fully pipelined, no
//   bubbles between words. The delay from input accept to out_valid is set by
//   the three root pipelines and the normalize divider, one bit a stage.
// A stalled output holds the whole back end; the 4-word queue lets the front
//   keep accepting until it fills.
// Reset: synchronous active-low rst_n clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module hashed_random_unit_vector import hru_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      push, pop;
  rnd_word_t push_word, pop_word;
  q_stat_t   q_stat;

  hru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_stat   (q_stat),
    .push     (push),
    .push_word(push_word)
  );

  hru_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_word(push_word),
    .pop      (pop),
    .pop_word (pop_word),
    .q_stat   (q_stat)
  );

  hru_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop      (pop),
    .pop_word (pop_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

[dv/hashed_random_unit_vector_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hashed_random_unit_vector_tb
// Drives seed triples through the block with random input gaps and output
// stalls, predicts each unit vector in fixed point and checks every word.
// ----------------------------------------------------------------------------
module hashed_random_unit_vector_tb;
  import hru_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam longint unsigned MASK32 = 64'hFFFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  out_word_t dir_q[$];
  int        n_sent;
  int        n_checked;
  int        n_degen;
  int        n_err;
  int        stall_cnt;
  bit        idle_on;

  hashed_random_unit_vector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [31:0] noise_hash(logic [31:0] v);
    v = v * NOISE_M1;
    v = v + HASH_BIAS;
    v = v ^ (v >> HASH_SH);
    v = v + NOISE_A2;
    v = v ^ (v << HASH_SH);
    v = v * NOISE_M3;
    v = v ^ (v >> HASH_SH);
    return v;
  endfunction

  function automatic logic [31:0] xs_next(logic [31:0] v);
    v = v ^ (v << XS_A);
    v = v ^ (v >> XS_B);
    v = v ^ (v << XS_C);
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned frac_of(logic [31:0] r);
    return ({32'd0, r} << FB) / MASK32;
  endfunction

  function automatic longint signed spread_of(longint unsigned half, longint unsigned f);
    longint unsigned t;
    t = (2 * half * f) >> FB;
    return longint'(t) - longint'(half);
  endfunction

  function automatic longint unsigned mag(longint signed v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [31:0] norm_comp(longint signed c, longint unsigned len);
    longint unsigned q;
    q = (mag(c) << FB) / len;
    if (c < 0) q = ~q + 1;
    return q[31:0];
  endfunction

  function automatic out_word_t predict_dir(in_word_t w);
    out_word_t       o;
    logic [31:0]     r;
    longint signed   x, y, z;
    longint unsigned x2, y2, rem, ymax, zmax, len2, len;
    r = noise_hash(w.seed_x + SEED_MUL_Y * w.seed_y + SEED_MUL_Z * w.seed_z);
    r = xs_next(r);
    x = longint'(2 * frac_of(r)) - longint'(ONE);
    x2 = (mag(x) * mag(x)) >> FB;
    ymax = root64((ONE - x2) << FB);
    r = xs_next(r);
    y = spread_of(ymax, frac_of(r));
    y2 = (mag(y) * mag(y)) >> FB;
    // negative remainder under the z root is clamped
    rem = (x2 + y2 >= ONE) ? 0 : ONE - x2 - y2;
    zmax = root64(rem << FB);
    r = xs_next(r);
    z = spread_of(zmax, frac_of(r));
    len2 = mag(x) * mag(x) + mag(y) * mag(y) + mag(z) * mag(z);
    o = '0;
    if (len2 == 0) begin
      o.degenerate = 1'b1;
    end else begin
      len = root64(len2);
      o.dir_x = norm_comp(x, len);
      o.dir_y = norm_comp(y, len);
      o.dir_z = norm_comp(z, len);
    end
    return o;
  endfunction

  // one word in; expectation queued at the accepting edge
  task automatic send_word(in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    dir_q.push_back(predict_dir(w));
    n_sent++;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_seed();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext[6];
    in_word_t    w;
    ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_AAAA};
    idle_on = 1'b0;
    for (int i = 0; i < 6; i++) begin
      w = '{ext[i], ext[i], ext[i]};
      send_word(w);
    end
    idle_on = 1'b1;
    // seed fold wrapping
    for (int i = 0; i < 6; i++) begin
      w = '{ext[i], ext[(i + 3) % 6], ext[(i + 5) % 6]};
      send_word(w);
    end
    for (int i = 0; i < 8; i++) begin
      w = '{32'(i), 32'(-i), 32'(i * 1000)};
      send_word(w);
    end
  endtask

  task automatic test_random(int count);
    in_word_t w;
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) idle_on = ($urandom_range(0, 3) != 0);
      w.seed_x = pick_seed();
      w.seed_y = pick_seed();
      w.seed_z = pick_seed();
      send_word(w);
    end
  endtask

  task automatic test_burst(int count);
    in_word_t w;
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      w = '{$urandom, $urandom, $urandom};
      send_word(w);
    end
    in_valid <= 1'b0;
  endtask

  // result side: random stall after each accepted word while idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cnt = 0;
    end else if (stall_cnt != 0) begin
      out_stall <= 1'b1;
      stall_cnt--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall && idle_on) stall_cnt = $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (dir_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word %h", out_word);
      end else begin
        exp_w = dir_q.pop_front();
        n_checked++;
        if (exp_w.degenerate) n_degen++;
        if (out_word.dir_x !== exp_w.dir_x || out_word.dir_y !== exp_w.dir_y ||
            out_word.dir_z !== exp_w.dir_z || out_word.degenerate !== exp_w.degenerate) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: exp x=%h y=%h z=%h d=%b got x=%h y=%h z=%h d=%b",
                     exp_w.dir_x, exp_w.dir_y, exp_w.dir_z, exp_w.degenerate,
                     out_word.dir_x, out_word.dir_y, out_word.dir_z, out_word.degenerate);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("hashed_random_unit_vector regression: fail");
    $finish;
  end

  initial begin
    int tail;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    idle_on   = 1'b1;
    n_sent    = 0;
    n_checked = 0;
    n_degen   = 0;
    n_err     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1450);
    test_burst(200);
    while (dir_q.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 4 * FB + 60) begin
      @(posedge clk);
      tail++;
    end
    if (dir_q.size() != 0) n_err++;
    $display("sent %0d seed words, checked %0d directions (%0d degenerate)",
             n_sent, n_checked, n_degen);
    $display("random gaps and output stalls on most phases, one back-to-back burst");
    if (n_err == 0) begin
      $display("hashed_random_unit_vector regression: pass");
    end else begin
      $display("%0d mismatches", n_err);
      $display("hashed_random_unit_vector regression: fail");
    end
    $finish;
  end

endmodule
